/* design/fba_pkg.sv */
// Shared types and constants for the block allocator with eager watermark.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fba_pkg;

    // default sizes handed to the top level parameters
    localparam int LIST_DEPTH_DEF = 1024;
    localparam int ADDR_WIDTH_DEF = 48;

    // fixed field widths
    localparam int CMD_W         = 2;
    localparam int STATUS_W      = 2;
    localparam int INDEX_W       = 32;
    localparam int FIRST_INDEX_W = 31;
    localparam int BPP_W         = 11;
    localparam int BLOCK_SIZE_W  = 32;
    localparam int LEVEL_W       = 11;
    localparam int FREE_COUNT_W  = 11;
    localparam int CFG_ADDR_W    = 3;

    // command codes
    localparam logic [CMD_W-1:0] CMD_INIT  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FREE  = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NULL  = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd3;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_FIRST_INDEX   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_BLOCKS        = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_REGION_BASE   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_BLOCK_SIZE    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_EAGER_START   = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_EAGER_FINISH  = 3'd5;

    // configuration reset values
    localparam logic [FIRST_INDEX_W-1:0] FIRST_INDEX_RST  = '0;
    localparam logic [BPP_W-1:0]         BLOCKS_RST       = 11'd1024;
    localparam logic [BLOCK_SIZE_W-1:0]  BLOCK_SIZE_RST   = 32'd4096;
    localparam logic [LEVEL_W-1:0]       EAGER_START_RST  = 11'd64;
    localparam logic [LEVEL_W-1:0]       EAGER_FINISH_RST = 11'd128;

    // controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_FILL,
        ST_ALLOC_READ,
        ST_ALLOC_POP,
        ST_ALLOC_SUM,
        ST_FREE_DIV,
        ST_FREE_PUSH,
        ST_RESULT
    } fba_state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic fill;
        logic pop;
        logic alloc_sum;
        logic div_step;
        logic push;
        logic load_out;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [CMD_W-1:0] op;
        logic             addr_null;
        logic             list_empty;
        logic             fill_done;
        logic             div_done;
        logic             out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

/* design/fba_ram.sv */
// Generic single write port, single read port RAM with registered read data.
// Holds the free list; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module fba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

/* design/fba_ctrl.sv */
// Controller state machine: sequences init fill, alloc and free steps.
// Depends on fba_pkg for the state enum and the command/status structs.
`timescale 1ns / 1ps
`default_nettype none

module fba_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire fba_pkg::dp_stat_t stat,
    output fba_pkg::dp_cmd_t       cmd
);

    import fba_pkg::*;

    fba_state_t state_reg;
    fba_state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                case (stat.op)
                    CMD_INIT:  state_next = ST_FILL;
                    CMD_ALLOC: state_next = stat.list_empty ? ST_RESULT : ST_ALLOC_READ;
                    CMD_FREE:  state_next = stat.addr_null ? ST_RESULT : ST_FREE_DIV;
                    default:   state_next = ST_RESULT;
                endcase
            end
            ST_FILL: begin
                if (stat.fill_done) begin
                    state_next = ST_RESULT;
                end
            end
            ST_ALLOC_READ: state_next = ST_ALLOC_POP;
            ST_ALLOC_POP:  state_next = ST_ALLOC_SUM;
            ST_ALLOC_SUM:  state_next = ST_RESULT;
            ST_FREE_DIV: begin
                if (stat.div_done) begin
                    state_next = ST_FREE_PUSH;
                end
            end
            ST_FREE_PUSH: state_next = ST_RESULT;
            ST_RESULT: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            ST_FILL:      cmd.fill      = !stat.fill_done;
            ST_ALLOC_POP: cmd.pop       = 1'b1;
            ST_ALLOC_SUM: cmd.alloc_sum = 1'b1;
            ST_FREE_DIV:  cmd.div_step  = !stat.div_done;
            ST_FREE_PUSH: cmd.push      = 1'b1;
            ST_RESULT:    cmd.load_out  = stat.out_free;
            default: ;
        endcase
    end

endmodule

`default_nettype wire

/* design/fba_dp.sv */
// Datapath: config registers, free list pointers and count, divider,
// multiplier, result and output registers. Depends on fba_pkg and fba_ram.
`timescale 1ns / 1ps
`default_nettype none

module fba_dp #(
    parameter int LIST_DEPTH = fba_pkg::LIST_DEPTH_DEF,
    parameter int ADDR_WIDTH = fba_pkg::ADDR_WIDTH_DEF,
    localparam int CFG_W = (ADDR_WIDTH > fba_pkg::BLOCK_SIZE_W) ?
                           ADDR_WIDTH : fba_pkg::BLOCK_SIZE_W
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_we,
    input  wire logic [fba_pkg::CFG_ADDR_W-1:0]   cfg_index,
    input  wire logic [CFG_W-1:0]                 cfg_wdata,
    input  wire logic [fba_pkg::CMD_W-1:0]        in_command,
    input  wire logic [ADDR_WIDTH-1:0]            in_block_address,
    input  wire fba_pkg::dp_cmd_t                 cmd,
    output fba_pkg::dp_stat_t                     stat,
    input  wire logic                             m_tready,
    output logic                                  m_tvalid,
    output logic [fba_pkg::STATUS_W-1:0]          m_status,
    output logic [ADDR_WIDTH-1:0]                 m_alloc_address,
    output logic [fba_pkg::INDEX_W-1:0]           m_block_index,
    output logic [fba_pkg::FREE_COUNT_W-1:0]      m_free_count,
    output logic                                  m_eager_flag
);

    import fba_pkg::*;

    localparam int PTR_W     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W     = $clog2(LIST_DEPTH + 1);
    localparam int CMP_W     = CNT_W + LEVEL_W;
    localparam int DIV_CNT_W = $clog2(ADDR_WIDTH + 1);
    localparam int PROD_W    = 2 * INDEX_W;

    // configuration registers
    logic [FIRST_INDEX_W-1:0] first_index_reg;
    logic [BPP_W-1:0]         blocks_reg;
    logic [ADDR_WIDTH-1:0]    base_reg;
    logic [BLOCK_SIZE_W-1:0]  bsize_reg;
    logic [LEVEL_W-1:0]       start_reg;
    logic [LEVEL_W-1:0]       finish_reg;

    // list state
    logic [PTR_W-1:0] head_reg;
    logic [PTR_W-1:0] tail_reg;
    logic [CNT_W-1:0] count_reg;
    logic             eager_reg;

    // per transaction working registers
    logic [CMD_W-1:0]      op_reg;
    logic                  null_reg;
    logic [CNT_W-1:0]      fill_cnt_reg;
    logic [CNT_W-1:0]      fill_n_reg;
    logic [ADDR_WIDTH-1:0] quo_reg;
    logic [BLOCK_SIZE_W:0] rem_reg;
    logic [DIV_CNT_W-1:0]  div_cnt_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic [STATUS_W-1:0]   res_status_reg;
    logic [ADDR_WIDTH-1:0] res_addr_reg;
    logic [INDEX_W-1:0]    res_idx_reg;
    logic                  m_tvalid_reg;

    // combinational helpers
    logic [PTR_W-1:0]      head_inc;
    logic [PTR_W-1:0]      tail_inc;
    logic                  list_full;
    logic [CNT_W-1:0]      fill_n_next;
    logic [INDEX_W-1:0]    fill_val;
    logic [INDEX_W-1:0]    rd_data;
    logic [INDEX_W-1:0]    idx_m1;
    logic [PROD_W-1:0]     prod_next;
    logic [CNT_W-1:0]      count_dec;
    logic [CNT_W-1:0]      count_push;
    logic                  eager_pop;
    logic                  eager_push;
    logic [BLOCK_SIZE_W:0] rem_sh;
    logic [BLOCK_SIZE_W:0] dvsr;
    logic                  rem_ge;
    logic [ADDR_WIDTH+INDEX_W-1:0] q_plus;
    logic [INDEX_W-1:0]    free_idx;
    logic [CMP_W-1:0]      count_x;
    logic [STATUS_W-1:0]   status_capture;
    logic                  ram_we;
    logic [INDEX_W-1:0]    ram_wdata;

    // pointer wrap and fullness
    assign head_inc  = (head_reg == PTR_W'(LIST_DEPTH - 1)) ? '0 : head_reg + PTR_W'(1);
    assign tail_inc  = (tail_reg == PTR_W'(LIST_DEPTH - 1)) ? '0 : tail_reg + PTR_W'(1);
    assign list_full = (count_reg == CNT_W'(LIST_DEPTH));

    // init length, clamped to the list depth
    assign fill_n_next = (CMP_W'(blocks_reg) > CMP_W'(LIST_DEPTH)) ?
                         CNT_W'(LIST_DEPTH) : CNT_W'(blocks_reg);
    assign fill_val    = {1'b0, first_index_reg} + INDEX_W'(fill_cnt_reg) + INDEX_W'(1);

    // alloc: index minus one times block size
    assign idx_m1    = rd_data - INDEX_W'(1);
    assign prod_next = PROD_W'(idx_m1) * PROD_W'(bsize_reg);

    // eager flag hysteresis
    assign count_dec  = count_reg - CNT_W'(1);
    assign eager_pop  = eager_reg ? !(CMP_W'(count_dec) > CMP_W'(finish_reg)) :
                                    (CMP_W'(count_dec) <= CMP_W'(start_reg));
    assign count_push = list_full ? count_reg : count_reg + CNT_W'(1);
    assign eager_push = eager_reg && !(CMP_W'(count_push) > CMP_W'(finish_reg));

    // restoring divider step, one quotient bit per cycle
    assign rem_sh = {rem_reg[BLOCK_SIZE_W-1:0], quo_reg[ADDR_WIDTH-1]};
    assign dvsr   = {1'b0, bsize_reg};
    assign rem_ge = (rem_sh >= dvsr);

    // freed index; a zero block size gives an all-ones quotient, so index zero
    assign q_plus   = (ADDR_WIDTH+INDEX_W)'(quo_reg) + (ADDR_WIDTH+INDEX_W)'(1);
    assign free_idx = (bsize_reg == '0) ? '0 : q_plus[INDEX_W-1:0];

    // status decided at capture
    always_comb begin
        status_capture = STAT_OK;
        if (in_command == CMD_ALLOC && count_reg == '0) begin
            status_capture = STAT_EMPTY;
        end else if (in_command == CMD_FREE && in_block_address == '0) begin
            status_capture = STAT_NULL;
        end
    end

    // free list memory
    assign ram_we    = cmd.fill || (cmd.push && !list_full);
    assign ram_wdata = cmd.fill ? fill_val : free_idx;

    fba_ram #(
        .WIDTH (INDEX_W),
        .DEPTH (LIST_DEPTH)
    ) u_list_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (tail_reg),
        .wr_data (ram_wdata),
        .rd_addr (head_reg),
        .rd_data (rd_data)
    );

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_index_reg <= FIRST_INDEX_RST;
            blocks_reg      <= BLOCKS_RST;
            base_reg        <= '0;
            bsize_reg       <= BLOCK_SIZE_RST;
            start_reg       <= EAGER_START_RST;
            finish_reg      <= EAGER_FINISH_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_FIRST_INDEX:  first_index_reg <= cfg_wdata[FIRST_INDEX_W-1:0];
                REG_BLOCKS:       blocks_reg      <= cfg_wdata[BPP_W-1:0];
                REG_REGION_BASE:  base_reg        <= cfg_wdata[ADDR_WIDTH-1:0];
                REG_BLOCK_SIZE:   bsize_reg       <= cfg_wdata[BLOCK_SIZE_W-1:0];
                REG_EAGER_START:  start_reg       <= cfg_wdata[LEVEL_W-1:0];
                REG_EAGER_FINISH: finish_reg      <= cfg_wdata[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    // list pointers, count and eager flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            eager_reg <= 1'b0;
        end else begin
            if (cmd.capture && in_command == CMD_INIT) begin
                head_reg  <= '0;
                tail_reg  <= '0;
                count_reg <= '0;
            end
            if (cmd.fill) begin
                tail_reg  <= tail_inc;
                count_reg <= count_reg + CNT_W'(1);
            end
            if (cmd.pop) begin
                head_reg  <= head_inc;
                count_reg <= count_dec;
                eager_reg <= eager_pop;
            end
            if (cmd.push) begin
                if (!list_full) begin
                    tail_reg <= tail_inc;
                end
                count_reg <= count_push;
                eager_reg <= eager_push;
            end
        end
    end

    // working registers for the transaction in flight
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg         <= in_command;
            null_reg       <= (in_block_address == '0);
            quo_reg        <= in_block_address - base_reg;
            rem_reg        <= '0;
            div_cnt_reg    <= '0;
            fill_cnt_reg   <= '0;
            fill_n_reg     <= fill_n_next;
            res_status_reg <= status_capture;
            res_addr_reg   <= '0;
            res_idx_reg    <= '0;
        end
        if (cmd.fill) begin
            fill_cnt_reg <= fill_cnt_reg + CNT_W'(1);
        end
        if (cmd.pop) begin
            res_idx_reg <= rd_data;
            prod_reg    <= prod_next;
        end
        if (cmd.alloc_sum) begin
            res_addr_reg <= (res_idx_reg == '0) ? '0 :
                            base_reg + prod_reg[ADDR_WIDTH-1:0];
        end
        if (cmd.div_step) begin
            rem_reg     <= rem_ge ? rem_sh - dvsr : rem_sh;
            quo_reg     <= {quo_reg[ADDR_WIDTH-2:0], rem_ge};
            div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
        end
        if (cmd.push) begin
            res_idx_reg <= free_idx;
            if (list_full) begin
                res_status_reg <= STAT_FULL;
            end
        end
    end

    // output register, frees the input side while a result waits
    assign count_x = CMP_W'(count_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_status        <= res_status_reg;
            m_alloc_address <= res_addr_reg;
            m_block_index   <= res_idx_reg;
            m_free_count    <= count_x[FREE_COUNT_W-1:0];
            m_eager_flag    <= eager_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;

    // status toward the controller
    assign stat.op         = op_reg;
    assign stat.addr_null  = null_reg;
    assign stat.list_empty = (count_reg == '0);
    assign stat.fill_done  = (fill_cnt_reg == fill_n_reg);
    assign stat.div_done   = (div_cnt_reg == DIV_CNT_W'(ADDR_WIDTH));
    assign stat.out_free   = !m_tvalid_reg || m_tready;

endmodule

`default_nettype wire

/* design/fifo_block_allocator_watermark.sv */
// FIFO free-list block allocator with eager watermark flag.
//
// Input stream (s_*): s_tuser carries the command (init, alloc, free) and
// s_tdata the block address to free. Every input transaction yields exactly
// one result transaction on m_*: m_tuser is the status, m_tdata carries the
// allocated address, the block index, the free count and the eager flag.
// Configuration is written through cfg_we/cfg_index/cfg_wdata; the user
// must do so only while idle, and the block leaves this unchecked.
//
// Items are handled one at a time by a controller and a datapath:
//   alloc ........ one RAM read plus a 32x32 multiply (none on an empty list)
//   free ......... bit-serial divider over ADDR_WIDTH quotient bits
//   init ......... one list entry written per cycle
//   null free, unused command ... no list work
// The result sits in an output register; s_tready rises again while it
// waits, so a stalled receiver only holds the block once the next result is
// ready. Reset (aresetn, synchronous, low) empties the list, clears the
// eager flag and loads the configuration defaults; the list RAM itself is
// not cleared, and an init command fills it.
`timescale 1ns / 1ps
`default_nettype none

module fifo_block_allocator_watermark #(
    parameter int LIST_DEPTH = fba_pkg::LIST_DEPTH_DEF,
    parameter int ADDR_WIDTH = fba_pkg::ADDR_WIDTH_DEF,
    localparam int CFG_W = (ADDR_WIDTH > fba_pkg::BLOCK_SIZE_W) ?
                           ADDR_WIDTH : fba_pkg::BLOCK_SIZE_W,
    localparam int S_TDATA_W = ((ADDR_WIDTH + 7) / 8) * 8,
    localparam int M_DATA_W  = ADDR_WIDTH + fba_pkg::INDEX_W + fba_pkg::FREE_COUNT_W + 1,
    localparam int M_TDATA_W = ((M_DATA_W + 7) / 8) * 8
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // configuration write port
    input  wire logic                           cfg_we,
    input  wire logic [fba_pkg::CFG_ADDR_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]               cfg_wdata,
    // input stream
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [S_TDATA_W-1:0]           s_tdata,  // block_address
    input  wire logic [fba_pkg::CMD_W-1:0]      s_tuser,  // command
    // result stream
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // alloc_address, block_index, free_count, eager_flag
    output logic [M_TDATA_W-1:0]                m_tdata,
    output logic [fba_pkg::STATUS_W-1:0]        m_tuser   // status
);

    import fba_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    logic [ADDR_WIDTH-1:0]   m_alloc_address;
    logic [INDEX_W-1:0]      m_block_index;
    logic [FREE_COUNT_W-1:0] m_free_count;
    logic                    m_eager_flag;

    // controller
    fba_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath
    fba_dp #(
        .LIST_DEPTH (LIST_DEPTH),
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .in_command       (s_tuser),
        .in_block_address (s_tdata[ADDR_WIDTH-1:0]),
        .cmd              (cmd),
        .stat             (stat),
        .m_tready         (m_tready),
        .m_tvalid         (m_tvalid),
        .m_status         (m_tuser),
        .m_alloc_address  (m_alloc_address),
        .m_block_index    (m_block_index),
        .m_free_count     (m_free_count),
        .m_eager_flag     (m_eager_flag)
    );

    // pack the result fields, lowest first
    assign m_tdata = M_TDATA_W'({m_eager_flag, m_free_count, m_block_index, m_alloc_address});

    // no datapath work while the block is taking a new transaction
    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !(cmd.fill || cmd.pop || cmd.alloc_sum || cmd.div_step ||
                       cmd.push || cmd.load_out))
        else $error("datapath command issued while idle");

    // at most one list operation per cycle
    a_one_list_op: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.fill, cmd.pop, cmd.push, cmd.div_step, cmd.capture}))
        else $error("overlapping list operations");

    // a result is only loaded when the output register can take it
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> stat.out_free)
        else $error("result overwrote a pending output");

    // a loaded result is presented in the next cycle
    a_load_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |=> m_tvalid)
        else $error("loaded result not presented");

endmodule

`default_nettype wire

/* sim/tb_fifo_block_allocator_watermark.sv */
// Self-checking testbench for the FIFO free-list block allocator with eager flag.
// Directed table then random pool sessions, each result checked against a local predictor or typed reply.
// Depends on fba_pkg and fifo_block_allocator_watermark.
`timescale 1ns / 1ps

module tb_fifo_block_allocator_watermark;

    import fba_pkg::*;

    localparam int LIST_DEPTH   = LIST_DEPTH_DEF;
    localparam int ADDR_W       = ADDR_WIDTH_DEF;
    localparam int CFG_W        = (ADDR_W > BLOCK_SIZE_W) ? ADDR_W : BLOCK_SIZE_W;
    localparam int S_TDATA_W    = ((ADDR_W + 7) / 8) * 8;
    localparam int M_DATA_W     = ADDR_W + INDEX_W + FREE_COUNT_W + 1;
    localparam int M_TDATA_W    = ((M_DATA_W + 7) / 8) * 8;
    localparam int IDX_LSB      = ADDR_W;
    localparam int CNT_LSB      = ADDR_W + INDEX_W;
    localparam int FLAG_BIT     = CNT_LSB + FREE_COUNT_W;

    localparam int CLK_PERIOD   = 10;
    localparam int LIMIT_CYCLES = 2_000_000;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 100;
    localparam int NUM_SESSIONS = 8;
    localparam int SESSION_LEN  = 210;
    localparam int DIR_LEN      = 33;

    // command value the block leaves unused
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic [ADDR_W-1:0]       addr;
        logic [INDEX_W-1:0]      index;
        logic [FREE_COUNT_W-1:0] count;
        logic                    flag;
    } reply_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CMD_W-1:0]      cmd;
        logic [CFG_ADDR_W-1:0] sel;
        logic [ADDR_W-1:0]     value;
        logic                  fixed;
        reply_t                reply;
    } dir_row_t;

    typedef enum logic [1:0] {RX_STREAM, RX_COIN, RX_SPARSE, RX_BURSTY} rx_mode_t;

    // dut signals
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]      cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;  // block_address
    logic [CMD_W-1:0]      s_tuser   = '0;  // command
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    // alloc_address, block_index, free_count, eager_flag
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [STATUS_W-1:0]   m_tuser;         // status

    // predictor copy of the free list and its registers
    logic [INDEX_W-1:0]       fl_entries [LIST_DEPTH];
    int                       fl_head  = 0;
    int                       fl_tail  = 0;
    int                       fl_count = 0;
    logic                     fl_eager = 1'b0;
    logic [FIRST_INDEX_W-1:0] c_first_index = FIRST_INDEX_RST;
    logic [BPP_W-1:0]         c_blocks      = BLOCKS_RST;
    logic [ADDR_W-1:0]        c_region_base = '0;
    logic [BLOCK_SIZE_W-1:0]  c_block_size  = BLOCK_SIZE_RST;
    logic [LEVEL_W-1:0]       c_start       = EAGER_START_RST;
    logic [LEVEL_W-1:0]       c_finish      = EAGER_FINISH_RST;

    reply_t             replies_due [$];
    logic [ADDR_W-1:0]  handed_out [$];
    int                 mismatches = 0;
    int                 burst_left = 0;
    bit                 hold_go    = 1'b0;

    // directed stimulus; typed replies only where obvious
    dir_row_t dir_rows [DIR_LEN] = '{
        '{ROW_ITEM, CMD_ALLOC,  REG_FIRST_INDEX,   48'h0,
          1'b1, '{STAT_EMPTY, 48'h0, 32'h0, 11'd0, 1'b0}},
        '{ROW_ITEM, CMD_FREE,   REG_FIRST_INDEX,   48'h0,
          1'b1, '{STAT_NULL, 48'h0, 32'h0, 11'd0, 1'b0}},
        '{ROW_ITEM, CMD_UNUSED, REG_FIRST_INDEX,   48'hFFFF_FFFF_FFFF,
          1'b1, '{STAT_OK, 48'h0, 32'h0, 11'd0, 1'b0}},
        '{ROW_ITEM, CMD_FREE,   REG_FIRST_INDEX,   48'h1000,
          1'b1, '{STAT_OK, 48'h0, 32'h2, 11'd1, 1'b0}},
        '{ROW_ITEM, CMD_ALLOC,  REG_FIRST_INDEX,   48'h0,
          1'b1, '{STAT_OK, 48'h1000, 32'h2, 11'd0, 1'b1}},
        '{ROW_CFG,  CMD_INIT,   REG_BLOCKS,        48'd4,              1'b0, '0},
        '{ROW_CFG,  CMD_INIT,   REG_FIRST_INDEX,   48'h7FFF_FFFF,      1'b0, '0},
        '{ROW_CFG,  CMD_INIT,   REG_REGION_BASE,   48'hFFFF_FFFF_F000, 1'b0, '0},
        '{ROW_CFG,  CMD_INIT,   REG_BLOCK_SIZE,    48'hFFFF_FFFF,      1'b0, '0},
        '{ROW_CFG,  CMD_INIT,   REG_EAGER_START,   48'd0,              1'b0, '0},
        '{ROW_CFG,  CMD_INIT,   REG_EAGER_FINISH,  48'd2,              1'b0, '0},
        '{ROW_ITEM, CMD_INIT,   REG_FIRST_INDEX,   48'h0,
          1'b1, '{STAT_OK, 48'h0, 32'h0, 11'd4, 1'b1}},
        '{ROW_ITEM, CMD_ALLOC,  REG_FIRST_INDEX,   48'h0,              1'b0, '0},
        '{ROW_ITEM, CMD_FREE,   REG_FIRST_INDEX,   48'hFFFF_FFFF_FFFF, 1'b0, '0},
        '{ROW_ITEM, CMD_FREE,   REG_FIRST_INDEX,   48'h1,              1'b0, '0},
        '{ROW_ITEM, CMD_ALLOC,  REG_FIRST_INDEX,   48'h0,              1'b0, '0},
        '{ROW_CFG,  CMD_INIT,   REG_BLOCK_SIZE,    48'd0,              1'b0, '0},
        '{ROW_CFG,  CMD_INIT,   REG_BLOCKS,        48'd0,              1'b0, '0},
        '{ROW_CFG,  CMD_INIT,   REG_REGION_BASE,   48'h0,              1'b0, '0},
        '{ROW_ITEM, CMD_INIT,   REG_FIRST_INDEX,   48'h0,              1'b0, '0},
        '{ROW_ITEM, CMD_FREE,   REG_FIRST_INDEX,   48'h5555_5555_5555, 1'b0, '0},
        '{ROW_ITEM, CMD_ALLOC,  REG_FIRST_INDEX,   48'h0,              1'b0, '0},
        '{ROW_ITEM, CMD_ALLOC,  REG_FIRST_INDEX,   48'h0,              1'b0, '0},
        '{ROW_CFG,  CMD_INIT,   REG_BLOCKS,        48'd2047,           1'b0, '0},
        '{ROW_CFG,  CMD_INIT,   REG_BLOCK_SIZE,    48'd1,              1'b0, '0},
        '{ROW_CFG,  CMD_INIT,   REG_EAGER_START,   48'd1024,           1'b0, '0},
        '{ROW_CFG,  CMD_INIT,   REG_EAGER_FINISH,  48'd1024,           1'b0, '0},
        '{ROW_CFG,  CMD_INIT,   REG_FIRST_INDEX,   48'h0,              1'b0, '0},
        '{ROW_ITEM, CMD_INIT,   REG_FIRST_INDEX,   48'h0,              1'b0, '0},
        '{ROW_ITEM, CMD_FREE,   REG_FIRST_INDEX,   48'hFFFF_FFFF_FFFF, 1'b0, '0},
        '{ROW_ITEM, CMD_FREE,   REG_FIRST_INDEX,   48'h1,              1'b0, '0},
        '{ROW_ITEM, CMD_ALLOC,  REG_FIRST_INDEX,   48'h0,              1'b0, '0},
        '{ROW_ITEM, CMD_ALLOC,  REG_FIRST_INDEX,   48'h0,              1'b0, '0}
    };

    fifo_block_allocator_watermark i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #(CLK_PERIOD / 2) aclk = 1'b1;
        #(CLK_PERIOD / 2) aclk = 1'b0;
    end

    // push onto the predicted free list; false when full
    function automatic bit list_push(input logic [INDEX_W-1:0] idx);
        if (fl_count >= LIST_DEPTH) return 1'b0;
        fl_entries[fl_tail] = idx;
        fl_tail = (fl_tail + 1) % LIST_DEPTH;
        fl_count++;
        return 1'b1;
    endfunction

    // apply one command to the predicted allocator and return its reply
    function automatic reply_t compute_reply(input logic [CMD_W-1:0] cmd,
                                             input logic [ADDR_W-1:0] addr);
        reply_t             r;
        int                 fill_n;
        logic [INDEX_W-1:0] idx;
        logic [INDEX_W-1:0] idx_less;
        logic [63:0]        prod;
        logic [ADDR_W-1:0]  diff;
        logic [63:0]        quot;
        r = '0;
        case (cmd)
            CMD_INIT: begin
                fill_n = (c_blocks > LIST_DEPTH) ? LIST_DEPTH : int'(c_blocks);
                fl_head  = 0;
                fl_tail  = 0;
                fl_count = 0;
                for (int i = 1; i <= fill_n; i++)
                    void'(list_push({1'b0, c_first_index} + INDEX_W'(i)));
            end
            CMD_ALLOC: begin
                if (fl_count == 0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    idx = fl_entries[fl_head];
                    fl_head = (fl_head + 1) % LIST_DEPTH;
                    fl_count--;
                    // a zero index pops as a null block
                    if (idx != '0) begin
                        idx_less = idx - 1'b1;
                        prod = {32'd0, idx_less} * {32'd0, c_block_size};
                        r.addr  = c_region_base + prod[ADDR_W-1:0];
                        r.index = idx;
                    end
                    // hysteresis between the two levels
                    if (fl_eager) begin
                        if (fl_count > int'(c_finish)) fl_eager = 1'b0;
                    end else if (fl_count <= int'(c_start)) begin
                        fl_eager = 1'b1;
                    end
                end
            end
            CMD_FREE: begin
                if (addr == '0) begin
                    r.status = STAT_NULL;
                end else begin
                    diff = addr - c_region_base;
                    quot = (c_block_size == '0) ? '1 : 64'(diff) / 64'(c_block_size);
                    idx = quot[INDEX_W-1:0] + 1'b1;
                    r.index = idx;
                    if (!list_push(idx)) r.status = STAT_FULL;
                    // a free can only clear the flag
                    if (fl_eager && fl_count > int'(c_finish)) fl_eager = 1'b0;
                end
            end
            default: ;
        endcase
        r.count = FREE_COUNT_W'(fl_count);
        r.flag  = fl_eager;
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] rand_addr();
        return ADDR_W'({$urandom(), $urandom()});
    endfunction

    // register write, one cycle of cfg_we
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] sel, input logic [ADDR_W-1:0] value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_wdata <= CFG_W'(value);
        @(negedge aclk);
        cfg_we    <= 1'b0;
        case (sel)
            REG_FIRST_INDEX:  c_first_index = value[FIRST_INDEX_W-1:0];
            REG_BLOCKS:       c_blocks      = value[BPP_W-1:0];
            REG_REGION_BASE:  c_region_base = value;
            REG_BLOCK_SIZE:   c_block_size  = value[BLOCK_SIZE_W-1:0];
            REG_EAGER_START:  c_start       = value[LEVEL_W-1:0];
            REG_EAGER_FINISH: c_finish      = value[LEVEL_W-1:0];
            default: ;
        endcase
    endtask

    // offer one transaction, then log its predicted reply
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr,
                             input logic fixed, input reply_t fixed_reply,
                             output reply_t predicted);
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= S_TDATA_W'(addr);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = compute_reply(cmd, addr);
        replies_due.push_back(fixed ? fixed_reply : predicted);
    endtask

    // bursts of back-to-back offers separated by random gaps
    task automatic sender_gap();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 10);
            gap = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 8) : $urandom_range(9, 70);
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    // stop offering and let every outstanding result come back
    task automatic wait_for_replies();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (replies_due.size() != 0) @(posedge aclk);
    endtask

    // result side: long hold on request, otherwise a rotating stall pattern
    initial begin : rx_pattern
        int rx_cycle;
        int stall_left;
        rx_cycle   = 0;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_go) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_go = 1'b0;
            end else begin
                rx_cycle++;
                case (rx_mode_t'((rx_cycle >> 8) & 3))
                    RX_STREAM: m_tready <= 1'b1;
                    RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
                    default: begin
                        if (stall_left > 0) begin
                            stall_left--;
                            m_tready <= 1'b0;
                        end else if ($urandom_range(0, 19) == 0) begin
                            stall_left = $urandom_range(5, 40);
                            m_tready <= 1'b0;
                        end else begin
                            m_tready <= 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    // compare each result transaction with the oldest predicted reply
    always @(posedge aclk) begin
        reply_t got;
        reply_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.status = m_tuser;
            got.addr   = m_tdata[ADDR_W-1:0];
            got.index  = m_tdata[IDX_LSB +: INDEX_W];
            got.count  = m_tdata[CNT_LSB +: FREE_COUNT_W];
            got.flag   = m_tdata[FLAG_BIT];
            if (replies_due.size() == 0) begin
                $error("result transaction with nothing outstanding");
                mismatches++;
            end else begin
                want = replies_due.pop_front();
                if (got.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    mismatches++;
                end
                if (got.addr !== want.addr) begin
                    $error("alloc_address: expected %h, got %h", want.addr, got.addr);
                    mismatches++;
                end
                if (got.index !== want.index) begin
                    $error("block_index: expected %h, got %h", want.index, got.index);
                    mismatches++;
                end
                if (got.count !== want.count) begin
                    $error("free_count: expected %0d, got %0d", want.count, got.count);
                    mismatches++;
                end
                if (got.flag !== want.flag) begin
                    $error("eager_flag: expected %0d, got %0d", want.flag, got.flag);
                    mismatches++;
                end
            end
        end
    end

    // stimulus
    initial begin
        reply_t                  rep;
        dir_row_t                row;
        int                      r;
        int                      k;
        int                      pool_n;
        logic [CMD_W-1:0]        cmd;
        logic [ADDR_W-1:0]       a;
        logic [BPP_W-1:0]        bpp_v;
        logic [LEVEL_W-1:0]      lv_start;
        logic [LEVEL_W-1:0]      lv_finish;
        logic [BLOCK_SIZE_W-1:0] bs_v;
        logic [INDEX_W-1:0]      blk;
        logic [63:0]             prod;

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed table
        for (int n = 0; n < DIR_LEN; n++) begin
            row = dir_rows[n];
            if (row.kind == ROW_CFG) begin
                wait_for_replies();
                write_reg(row.sel, row.value);
            end else begin
                send_item(row.cmd, row.value, row.fixed, row.reply, rep);
                sender_gap();
            end
        end

        // random sessions, each with its own pool setup
        for (int p = 0; p < NUM_SESSIONS; p++) begin
            wait_for_replies();
            if (p == 2)      bpp_v = 11'd1024;
            else if (p == 5) bpp_v = BPP_W'($urandom_range(1025, 2047));
            else             bpp_v = BPP_W'($urandom_range(1, 48));
            pool_n = (bpp_v > LIST_DEPTH) ? LIST_DEPTH : int'(bpp_v);
            if (p == 7) begin
                bs_v = '0;
            end else begin
                case ($urandom_range(0, 3))
                    0:       bs_v = BLOCK_SIZE_W'(1) << $urandom_range(0, 16);
                    1:       bs_v = BLOCK_SIZE_W'($urandom_range(1, 5000));
                    2:       bs_v = $urandom();
                    default: bs_v = '1;
                endcase
            end
            if (p == 1) begin
                lv_start  = 11'd1024;
                lv_finish = 11'd0;
            end else if (p == 6) begin
                lv_start  = 11'd0;
                lv_finish = 11'd1024;
            end else begin
                lv_start  = LEVEL_W'($urandom_range(0, pool_n));
                lv_finish = LEVEL_W'($urandom_range(int'(lv_start), pool_n));
            end
            write_reg(REG_FIRST_INDEX, (p == 0) ? '0 :
                                       (p == 3) ? 48'h7FFF_FFFF : ADDR_W'($urandom() >> 1));
            write_reg(REG_BLOCKS, bpp_v);
            write_reg(REG_REGION_BASE, (p == 4) ? '0 : rand_addr());
            write_reg(REG_BLOCK_SIZE, bs_v);
            write_reg(REG_EAGER_START, lv_start);
            write_reg(REG_EAGER_FINISH, lv_finish);

            handed_out.delete();
            send_item(CMD_INIT, rand_addr(), 1'b0, '0, rep);
            sender_gap();

            for (int n = 1; n < SESSION_LEN; n++) begin
                // long result hold while offers keep coming
                if (p == 1 && n == 40) hold_go = 1'b1;
                // sender pause until the block has drained
                if (p == 3 && n == 100) wait_for_replies();

                r = $urandom_range(0, 99);
                if (r < 40 || r >= 97) begin
                    cmd = CMD_ALLOC;
                    a   = rand_addr();
                end else if (r < 72 && handed_out.size() > 0) begin
                    // give back a block handed out earlier, maybe pointing inside it
                    cmd = CMD_FREE;
                    k   = $urandom_range(0, handed_out.size() - 1);
                    a   = handed_out[k];
                    handed_out.delete(k);
                    if (c_block_size > 1 && $urandom_range(0, 1) == 1)
                        a = a + ADDR_W'($urandom_range(0, c_block_size - 1));
                end else if (r < 82) begin
                    // any block of the pool or the one just past it, double frees included
                    cmd  = CMD_FREE;
                    blk  = {1'b0, c_first_index} + INDEX_W'($urandom_range(0, pool_n));
                    prod = {32'd0, blk} * {32'd0, c_block_size};
                    a    = c_region_base + prod[ADDR_W-1:0];
                end else if (r < 87) begin
                    cmd = CMD_FREE;
                    a   = rand_addr();
                end else if (r < 91) begin
                    cmd = CMD_FREE;
                    a   = '0;
                end else if (r < 93) begin
                    cmd = CMD_UNUSED;
                    a   = rand_addr();
                end else begin
                    cmd = CMD_INIT;
                    a   = rand_addr();
                end

                send_item(cmd, a, 1'b0, '0, rep);
                if (cmd == CMD_ALLOC && rep.status == STAT_OK && rep.index != '0)
                    handed_out.push_back(rep.addr);
                if (cmd == CMD_INIT)
                    handed_out.delete();
                sender_gap();
            end
        end

        wait_for_replies();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0 && replies_due.size() == 0) begin
            $display("tb_fifo_block_allocator_watermark: clean");
        end else begin
            $display("tb_fifo_block_allocator_watermark: errors");
        end
        $finish;
    end

    // run limit
    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("tb_fifo_block_allocator_watermark: errors");
        $finish;
    end

endmodule
